// ===== hw/rtl/lfsp_pkg.sv =====
// Shared types and constants for the LED frame sequence player.
// Used by lfsp_ctrl, lfsp_datapath and led_frame_sequence_player_core.
// No dependencies.
package lfsp_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_PIXEL_COUNT = 32;
  localparam int DEF_FRAME_LIMIT = 1024;

  // Field widths fixed by the word formats
  localparam int OP_W       = 2;
  localparam int FNUM_W     = 10;
  localparam int PIX_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int TIME_W     = 32;
  localparam int FRM_W      = 11;   // current frame / frame count
  localparam int PERIOD_W   = 20;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // Config port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FRAME_COUNT  = 1'b0;
  localparam logic REG_FRAME_PERIOD = 1'b1;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd33333;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_PLAY  = 2'd1,
    OP_STOP  = 2'd2,
    OP_TIME  = 2'd3
  } op_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // latch accepted word
    logic mem_write;  // store byte of latched word
    logic play;       // restart at frame 0
    logic halt;       // stop playback, all-off update
    logic step;       // current frame + 1
    logic ref_add;    // reference += period
    logic ref_sync;   // reference = now
    logic emit;       // stream pixels of the update
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic loaded_zero;
    logic playing;
    logic due;
    logic at_end;
    logic behind;
    logic issue_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/lfsp_ctrl.sv =====
// Sequencing state machine of the LED frame sequence player.
// Depends on lfsp_pkg; drives lfsp_datapath through dp_cmd_t.
module lfsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lfsp_pkg::dp_status_t status,
  output lfsp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_RESYNC,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.op)
          lfsp_pkg::OP_WRITE: begin
            cmd.mem_write = 1'b1;
            state_nxt     = S_IDLE;
          end
          lfsp_pkg::OP_PLAY: begin
            if (status.loaded_zero) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.play  = 1'b1;
              state_nxt = S_EMIT;
            end
          end
          lfsp_pkg::OP_STOP: begin
            cmd.halt  = 1'b1;
            state_nxt = S_EMIT;
          end
          lfsp_pkg::OP_TIME: begin
            if (status.playing && status.due) begin
              cmd.step  = 1'b1;
              state_nxt = S_CHECK;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_CHECK: begin
        if (status.at_end) begin
          cmd.halt = 1'b1;
        end else begin
          cmd.ref_add = 1'b1;
        end
        state_nxt = status.at_end ? S_EMIT : S_RESYNC;
      end
      S_RESYNC: begin
        cmd.ref_sync = status.behind;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (status.issue_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/lfsp_datapath.sv =====
// Datapath of the LED frame sequence player: frame store, playback state,
// timing compare and the pixel read / output pipeline. Depends on lfsp_pkg.
module lfsp_datapath #(
  parameter int PIXEL_COUNT = lfsp_pkg::DEF_PIXEL_COUNT,
  parameter int FRAME_LIMIT = lfsp_pkg::DEF_FRAME_LIMIT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lfsp_pkg::dp_cmd_t                   cmd,
  output lfsp_pkg::dp_status_t                status,
  // accepted word fields
  input  lfsp_pkg::op_t                       in_op,
  input  logic [lfsp_pkg::FNUM_W-1:0]         in_fnum,
  input  logic [lfsp_pkg::PIX_W-1:0]          in_pnum,
  input  logic [lfsp_pkg::BYTE_W-1:0]         in_byte,
  input  logic [lfsp_pkg::TIME_W-1:0]         in_now,
  // config
  input  logic [lfsp_pkg::FRM_W-1:0]          frame_count,
  input  logic [lfsp_pkg::PERIOD_W-1:0]       frame_period,
  // result stream
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lfsp_pkg::PIX_W-1:0]          out_pixel,
  output logic [lfsp_pkg::BYTE_W-1:0]         out_white,
  output logic [lfsp_pkg::FNUM_W-1:0]         out_frame,
  output logic                                out_last,
  output logic                                out_playing
);

  localparam int DEPTH  = FRAME_LIMIT * PIXEL_COUNT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int LIM_W  = ($clog2(FRAME_LIMIT + 1) > lfsp_pkg::FRM_W) ?
                          $clog2(FRAME_LIMIT + 1) : lfsp_pkg::FRM_W;
  localparam int PCMP_W = ($clog2(PIXEL_COUNT + 1) > lfsp_pkg::PIX_W) ?
                          $clog2(PIXEL_COUNT + 1) : lfsp_pkg::PIX_W;

  // latched word
  lfsp_pkg::op_t                 op_r;
  logic [lfsp_pkg::FNUM_W-1:0]   fnum_r;
  logic [lfsp_pkg::PIX_W-1:0]    pnum_r;
  logic [lfsp_pkg::BYTE_W-1:0]   byte_r;
  logic [lfsp_pkg::TIME_W-1:0]   now_r;

  // playback state
  logic                          playing_r;
  logic                          show_r;
  logic [lfsp_pkg::FRM_W-1:0]    cur_r;
  logic [lfsp_pkg::TIME_W-1:0]   ref_r;

  // pixel pipeline
  logic [CW-1:0]                 cnt_r;
  logic                          s1_v_r;
  logic [lfsp_pkg::PIX_W-1:0]    s1_pix_r;
  logic                          s1_last_r;
  logic                          s1_show_r;
  logic [lfsp_pkg::FNUM_W-1:0]   s1_frame_r;
  logic                          s1_play_r;
  logic [lfsp_pkg::BYTE_W-1:0]   rdata_r;
  logic                          out_v_r;
  logic [lfsp_pkg::PIX_W-1:0]    out_pix_r;
  logic [lfsp_pkg::BYTE_W-1:0]   out_white_r;
  logic [lfsp_pkg::FNUM_W-1:0]   out_frame_r;
  logic                          out_last_r;
  logic                          out_play_r;

  logic [lfsp_pkg::BYTE_W-1:0]   mem [DEPTH];

  logic [LIM_W-1:0]              fc_ext, lim, loaded;
  logic [lfsp_pkg::TIME_W-1:0]   diff, period_ext;
  logic                          wr_in_range, we, issue, out_free, cnt_last;
  logic [AW-1:0]                 waddr, raddr;

  assign fc_ext     = LIM_W'(frame_count);
  assign lim        = LIM_W'(FRAME_LIMIT);
  assign loaded     = (fc_ext > lim) ? lim : fc_ext;
  assign period_ext = lfsp_pkg::TIME_W'(frame_period);
  assign diff       = now_r - ref_r;

  assign wr_in_range = (LIM_W'(fnum_r) < lim) &&
                       (PCMP_W'(pnum_r) < PCMP_W'(PIXEL_COUNT));
  assign we    = cmd.mem_write && wr_in_range;
  assign waddr = AW'(AW'(fnum_r) * AW'(PIXEL_COUNT) + AW'(pnum_r));
  assign raddr = AW'(AW'(cur_r) * AW'(PIXEL_COUNT) + AW'(cnt_r));

  assign out_free = !out_v_r || out_ready;
  assign issue    = cmd.emit && (!s1_v_r || out_free);
  assign cnt_last = (cnt_r == CW'(PIXEL_COUNT - 1));

  assign status.op          = op_r;
  assign status.loaded_zero = (loaded == '0);
  assign status.playing     = playing_r;
  assign status.due         = (diff >= period_ext);
  assign status.behind      = (diff > period_ext);
  assign status.at_end      = (LIM_W'(cur_r) >= loaded) || (cur_r == '0);
  assign status.issue_last  = issue && cnt_last;

  // word latch, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      fnum_r <= in_fnum;
      pnum_r <= in_pnum;
      byte_r <= in_byte;
      now_r  <= in_now;
    end
  end

  // playback state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      show_r    <= 1'b0;
      cur_r     <= '0;
      ref_r     <= '0;
    end else begin
      if (cmd.play) begin
        playing_r <= 1'b1;
        show_r    <= 1'b1;
        cur_r     <= '0;
        ref_r     <= now_r;
      end
      if (cmd.halt) begin
        playing_r <= 1'b0;
        show_r    <= 1'b0;
        cur_r     <= '0;
      end
      if (cmd.step) begin
        cur_r <= cur_r + 1'b1;
      end
      if (cmd.ref_add) begin
        ref_r  <= ref_r + period_ext;
        show_r <= 1'b1;
      end
      if (cmd.ref_sync) begin
        ref_r <= now_r;
      end
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= byte_r;
    end
    if (issue) begin
      rdata_r <= mem[raddr];
    end
  end

  // pixel counter and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_last ? '0 : cnt_r + 1'b1;
      end
      if (issue) begin
        s1_v_r <= 1'b1;
      end else if (out_free) begin
        s1_v_r <= 1'b0;
      end
      if (s1_v_r && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pix_r   <= lfsp_pkg::PIX_W'(cnt_r);
      s1_last_r  <= cnt_last;
      s1_show_r  <= show_r;
      s1_frame_r <= show_r ? cur_r[lfsp_pkg::FNUM_W-1:0] : '0;
      s1_play_r  <= playing_r;
    end
    if (s1_v_r && out_free) begin
      out_pix_r   <= s1_pix_r;
      out_white_r <= s1_show_r ? rdata_r : '0;
      out_frame_r <= s1_frame_r;
      out_last_r  <= s1_last_r;
      out_play_r  <= s1_play_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_pixel   = out_pix_r;
  assign out_white   = out_white_r;
  assign out_frame   = out_frame_r;
  assign out_last    = out_last_r;
  assign out_playing = out_play_r;

endmodule

// ===== hw/rtl/led_frame_sequence_player_core.sv =====
// Top level of the LED frame sequence player: config registers, stream
// packing, controller and datapath. Depends on lfsp_pkg, lfsp_ctrl, lfsp_datapath.
//
// Stores an LED animation of FRAME_LIMIT frames x PIXEL_COUNT white bytes and
// plays it back. Input words: write byte, play (restart at frame 0),
// stop (all-off update) and time update (now_us; advances a frame once a full
// frame period has elapsed, with 32-bit wrap). Every strip update streams
// PIXEL_COUNT result words, one per cycle when out_tready stays high. The
// pixel loop is bounded by the single read port of the frame store, one byte
// a cycle. Input is taken again once the last pixel read is issued, while the
// output register still drains. The frame store has no reset and no clearing
// pass: reading a byte that was never written gives an undefined level.
module led_frame_sequence_player_core #(
  parameter int PIXEL_COUNT = lfsp_pkg::DEF_PIXEL_COUNT,
  parameter int FRAME_LIMIT = lfsp_pkg::DEF_FRAME_LIMIT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [9:0] frame_number, [14:10] pixel_number, [22:15] byte_value,
  // [54:23] now_us, [55] zero
  input  logic [lfsp_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] operation
  input  logic [lfsp_pkg::OP_W-1:0]          in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [4:0] pixel_index, [12:5] white_level, [22:13] shown_frame,
  // [23] playing_now
  output logic [lfsp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,   // last_pixel
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lfsp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lfsp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lfsp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  // config registers
  logic [lfsp_pkg::FRM_W-1:0]    frame_count_r;
  logic [lfsp_pkg::PERIOD_W-1:0] frame_period_r;
  logic                          cfg_wr;
  logic                          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= '0;
      frame_period_r <= lfsp_pkg::PERIOD_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        lfsp_pkg::REG_FRAME_COUNT:  frame_count_r  <= pwdata[lfsp_pkg::FRM_W-1:0];
        lfsp_pkg::REG_FRAME_PERIOD: frame_period_r <= pwdata[lfsp_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lfsp_pkg::REG_FRAME_COUNT:  prdata = lfsp_pkg::CFG_DATA_W'(frame_count_r);
      lfsp_pkg::REG_FRAME_PERIOD: prdata = lfsp_pkg::CFG_DATA_W'(frame_period_r);
      default:                    prdata = '0;
    endcase
  end

  // controller <-> datapath
  lfsp_pkg::dp_cmd_t    dp_cmd;
  lfsp_pkg::dp_status_t dp_status;

  logic [lfsp_pkg::PIX_W-1:0]  res_pixel;
  logic [lfsp_pkg::BYTE_W-1:0] res_white;
  logic [lfsp_pkg::FNUM_W-1:0] res_frame;
  logic                        res_playing;

  lfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  lfsp_datapath #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .status       (dp_status),
    .in_op        (lfsp_pkg::op_t'(in_tuser)),
    .in_fnum      (in_tdata[9:0]),
    .in_pnum      (in_tdata[14:10]),
    .in_byte      (in_tdata[22:15]),
    .in_now       (in_tdata[54:23]),
    .frame_count  (frame_count_r),
    .frame_period (frame_period_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_pixel    (res_pixel),
    .out_white    (res_white),
    .out_frame    (res_frame),
    .out_last     (out_tlast),
    .out_playing  (res_playing)
  );

  assign out_tdata = {res_playing, res_frame, res_white, res_pixel};

  // Issuing the last pixel read hands control back to the input side.
  a_last_issue_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    dp_status.issue_last |=> in_tready)
    else $error("input not ready after last pixel issued");

  // A shown frame other than zero only comes from an advance while playing.
  a_frame_implies_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_frame != '0) |-> res_playing)
    else $error("nonzero frame shown while stopped");

  // An update made while stopped is all off.
  a_stopped_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res_playing) |-> (res_white == '0 && res_frame == '0))
    else $error("stopped update not all off");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for led_frame_sequence_player_core.
// Streams write/play/stop/time words, predicts every pixel word of each strip update.
// Depends on lfsp_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam int PIX    = lfsp_pkg::DEF_PIXEL_COUNT;
  localparam int FRAMES = lfsp_pkg::DEF_FRAME_LIMIT;
  localparam int MEM    = PIX * FRAMES;

  // register byte addresses: register i at 4*i
  localparam logic [lfsp_pkg::CFG_ADDR_W-1:0] ADDR_COUNT  =
    {lfsp_pkg::REG_FRAME_COUNT, 2'b00};
  localparam logic [lfsp_pkg::CFG_ADDR_W-1:0] ADDR_PERIOD =
    {lfsp_pkg::REG_FRAME_PERIOD, 2'b00};

  // one input word, plus a flag that holds it back until all pixels are out
  typedef struct {
    lfsp_pkg::op_t op;
    bit [9:0]      fnum;
    bit [4:0]      pnum;
    bit [7:0]      level;
    bit [31:0]     now;
    bit            hold;
  } word_t;

  // what one input word does to the strip
  typedef struct {
    bit       emit;
    bit       show;
    bit [9:0] frame;
    bit       playing;
  } strip_t;

  // one expected pixel word
  typedef struct {
    bit [4:0] pixel;
    bit [7:0] level;
    bit [9:0] frame;
    bit       last;
    bit       playing;
  } pix_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [lfsp_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [lfsp_pkg::OP_W-1:0]       in_tuser = lfsp_pkg::OP_WRITE;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lfsp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [lfsp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [lfsp_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [lfsp_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  // Two copies of the player state: side 0 runs ahead as the stimulus is
  // planned (so random words can be steered away from unwritten frames),
  // side 1 follows the words the core actually accepts and feeds the checker.
  bit        on_air    [2];
  bit [10:0] cur_frm   [2];
  bit [31:0] ref_us    [2];
  bit [10:0] cnt_reg   [2];
  bit [19:0] per_reg   [2];
  bit [7:0]  level_mem [2][MEM];
  bit        px_done   [2][MEM];
  int        filled_px [2][FRAMES];

  word_t pend_words[$];   // planned, not yet on the bus
  pix_t  pix_expect[$];   // pixel words still owed by the core
  word_t cur_word;        // word currently on in_tdata

  bit calm = 1'b0;        // stretch with no idling on either side
  int gap_left = 0;
  int stall_left = 0;
  int err_cnt = 0;
  int n_in = 0;
  int n_out = 0;
  int n_updates = 0;
  int n_settings = 0;

  led_frame_sequence_player_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Player prediction
  // ---------------------------------------------------------------------------

  // frame_count saturates at the store depth
  function automatic int loaded(int s);
    return (cnt_reg[s] > FRAMES) ? FRAMES : int'(cnt_reg[s]);
  endfunction

  function automatic strip_t halt_play(int s);
    strip_t st;
    on_air[s]  = 1'b0;
    cur_frm[s] = '0;
    st = '{emit: 1'b1, show: 1'b0, frame: '0, playing: 1'b0};
    return st;
  endfunction

  function automatic strip_t player_step(int s, word_t w);
    strip_t    st;
    bit [31:0] dt;
    bit [10:0] nxt;
    int        idx;
    st = '{emit: 1'b0, show: 1'b0, frame: '0, playing: 1'b0};
    case (w.op)
      lfsp_pkg::OP_WRITE: begin
        idx = int'(w.fnum) * PIX + int'(w.pnum);
        level_mem[s][idx] = w.level;
        if (!px_done[s][idx]) begin
          px_done[s][idx] = 1'b1;
          filled_px[s][w.fnum]++;
        end
      end
      lfsp_pkg::OP_PLAY: begin
        if (loaded(s) != 0) begin
          cur_frm[s] = '0;
          on_air[s]  = 1'b1;
          ref_us[s]  = w.now;
          st = '{emit: 1'b1, show: 1'b1, frame: '0, playing: 1'b1};
        end
      end
      lfsp_pkg::OP_STOP: st = halt_play(s);
      default: begin
        dt = w.now - ref_us[s];
        if (on_air[s] && dt >= per_reg[s]) begin
          nxt = cur_frm[s] + 11'd1;   // 11-bit wrap
          cur_frm[s] = nxt;
          if (nxt >= loaded(s) || nxt == 0) begin
            st = halt_play(s);
          end else begin
            ref_us[s] = ref_us[s] + per_reg[s];
            dt = w.now - ref_us[s];
            if (dt > per_reg[s]) ref_us[s] = w.now;   // too far behind: resync
            st = '{emit: 1'b1, show: 1'b1, frame: nxt[9:0], playing: 1'b1};
          end
        end
      end
    endcase
    return st;
  endfunction

  // would this word make the core show a frame with unwritten pixels
  function automatic bit reads_unfilled(int s, word_t w);
    bit [31:0] dt;
    bit [10:0] nxt;
    dt  = w.now - ref_us[s];
    nxt = cur_frm[s] + 11'd1;
    if (w.op == lfsp_pkg::OP_PLAY)
      return loaded(s) != 0 && filled_px[s][0] < PIX;
    if (w.op == lfsp_pkg::OP_TIME && on_air[s] && dt >= per_reg[s] &&
        nxt < loaded(s) && nxt != 0)
      return filled_px[s][nxt] < PIX;
    return 1'b0;
  endfunction

  // turn a strip update into the pixel words it owes
  function automatic void queue_strip(strip_t st);
    pix_t e;
    if (!st.emit) return;
    n_updates++;
    for (int i = 0; i < PIX; i++) begin
      e.pixel   = i[4:0];
      e.level   = st.show ? level_mem[1][int'(st.frame) * PIX + i] : 8'd0;
      e.frame   = st.show ? st.frame : 10'd0;
      e.last    = (i == PIX - 1);
      e.playing = st.playing;
      pix_expect.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------

  function automatic word_t any_word(lfsp_pkg::op_t op);
    word_t w;
    w.op    = op;
    w.fnum  = 10'($urandom_range(0, FRAMES - 1));
    w.pnum  = 5'($urandom_range(0, PIX - 1));
    w.level = 8'($urandom);
    w.now   = $urandom;
    w.hold  = 1'b0;
    return w;
  endfunction

  // steer the word away from unwritten frames, then plan it
  function automatic void send(word_t w);
    if (reads_unfilled(0, w)) begin
      if (w.op == lfsp_pkg::OP_TIME && per_reg[0] != 0)
        w.now = ref_us[0] + $urandom_range(0, per_reg[0] - 1);
      else
        w.op = lfsp_pkg::OP_STOP;
    end
    void'(player_step(0, w));
    pend_words.push_back(w);
  endfunction

  function automatic void send_at(lfsp_pkg::op_t op, bit [31:0] now, bit hold = 1'b0);
    word_t w;
    w      = any_word(op);
    w.now  = now;
    w.hold = hold;
    send(w);
  endfunction

  // time stamps around the period boundary of the planned state
  function automatic bit [31:0] pick_now();
    bit [31:0] b;
    bit [31:0] p;
    b = ref_us[0];
    p = per_reg[0];
    case ($urandom_range(0, 9))
      0, 1, 2: return (p == 0) ? b : b + $urandom_range(0, p - 1);
      3, 4:    return b + p;
      5, 6:    return b + p + $urandom_range(0, p);
      7, 8:    return b + 2 * p + $urandom_range(1, 5000);
      default: return $urandom;
    endcase
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: presents planned words, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    word_t nx;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if ($urandom_range(0, 99) < 2) calm = !calm;
      if (in_tvalid && in_tready) begin
        queue_strip(player_step(1, cur_word));
        n_in++;
      end
      // slot is free after this edge unless a word is still waiting on ready
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pend_words.size() != 0 &&
                     (!pend_words[0].hold || pix_expect.size() == 0)) begin
          nx = pend_words.pop_front();
          cur_word = nx;
          in_tdata <= {1'b0, nx.now, nx.level, nx.pnum, nx.fnum};
          in_tuser <= nx.op;
          in_tvalid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: random back-pressure, checks each pixel word in order
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : watch_out
    pix_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pix_expect.size() == 0) begin
          $display("%0t: unexpected word, expected none, got data %h last %b",
                   $time, out_tdata, out_tlast);
          err_cnt++;
        end else begin
          e = pix_expect.pop_front();
          check_field("pixel_index", e.pixel,   out_tdata[4:0]);
          check_field("white_level", e.level,   out_tdata[12:5]);
          check_field("shown_frame", e.frame,   out_tdata[22:13]);
          check_field("playing_now", e.playing, out_tdata[23]);
          check_field("last_pixel",  e.last,    out_tlast);
          n_out++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Config port and sequencing
  // ---------------------------------------------------------------------------

  // setup + access; a read compares prdata with data
  task automatic apb_access(bit wr, logic [lfsp_pkg::CFG_ADDR_W-1:0] addr,
                            logic [lfsp_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wr ? data : '0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== data) begin
      $display("%0t: register read at %0d, expected %0d, got %0d", $time, addr, data, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(bit [10:0] cnt, bit [19:0] per);
    apb_access(1'b1, ADDR_COUNT,  32'(cnt));
    apb_access(1'b1, ADDR_PERIOD, 32'(per));
    apb_access(1'b0, ADDR_COUNT,  32'(cnt));
    apb_access(1'b0, ADDR_PERIOD, 32'(per));
    cnt_reg[0] = cnt;
    cnt_reg[1] = cnt;
    per_reg[0] = per;
    per_reg[1] = per;
    n_settings++;
  endtask

  // wait for every planned word and owed pixel, then the core's own latency;
  // sampled at the falling edge so the driver's updates have settled
  task automatic drain();
    while (pend_words.size() != 0 || in_tvalid || pix_expect.size() != 0) @(negedge clk);
    repeat (PIX + 40) @(posedge clk);
  endtask

  initial begin : run
    word_t w;
    int    r;
    per_reg[0] = lfsp_pkg::PERIOD_RESET;
    per_reg[1] = lfsp_pkg::PERIOD_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // registers come up at their reset values
    apb_access(1'b0, ADDR_COUNT,  '0);
    apb_access(1'b0, ADDR_PERIOD, 32'(lfsp_pkg::PERIOD_RESET));

    // idle corner cases: play with nothing loaded, time while stopped,
    // stop while already stopped, writes at the field extremes
    send_at(lfsp_pkg::OP_PLAY, $urandom);
    send_at(lfsp_pkg::OP_TIME, $urandom);
    send_at(lfsp_pkg::OP_STOP, $urandom);
    w = any_word(lfsp_pkg::OP_WRITE);
    w.fnum = 10'(FRAMES - 1); w.pnum = 5'(PIX - 1); w.level = 8'hFF;
    send(w);
    w = any_word(lfsp_pkg::OP_WRITE);
    w.fnum = '0; w.pnum = '0; w.level = 8'h00;
    send(w);

    // load frames 0..2 completely; frame 0 carries both level extremes
    for (int f = 0; f < 3; f++) begin
      for (int p = 0; p < PIX; p++) begin
        w = any_word(lfsp_pkg::OP_WRITE);
        w.fnum = 10'(f);
        w.pnum = (f == 1) ? 5'(PIX - 1 - p) : 5'(p);
        if (f == 0 && p == 0) w.level = 8'h00;
        if (f == 0 && p == PIX - 1) w.level = 8'hFF;
        send(w);
      end
    end
    drain();

    // three frames, short period: play across the 32-bit wrap, just short,
    // exactly one period, far behind (resync), run off the end
    set_regs(11'd3, 20'd100);
    send_at(lfsp_pkg::OP_PLAY, 32'hFFFF_FFC0);
    send_at(lfsp_pkg::OP_TIME, ref_us[0] + 99);
    send_at(lfsp_pkg::OP_TIME, ref_us[0] + 100);
    send_at(lfsp_pkg::OP_TIME, ref_us[0] + 450);
    send_at(lfsp_pkg::OP_TIME, ref_us[0] + 100);
    send_at(lfsp_pkg::OP_TIME, $urandom);
    send_at(lfsp_pkg::OP_PLAY, $urandom, 1'b1);   // sender holds until the strip is idle
    send_at(lfsp_pkg::OP_STOP, $urandom);
    drain();

    // zero period and a count above the store depth
    set_regs(11'h7FF, 20'd0);
    send_at(lfsp_pkg::OP_PLAY, $urandom);
    send_at(lfsp_pkg::OP_TIME, $urandom);
    send_at(lfsp_pkg::OP_TIME, $urandom);
    send_at(lfsp_pkg::OP_STOP, $urandom);
    send_at(lfsp_pkg::OP_PLAY, $urandom);
    send_at(lfsp_pkg::OP_TIME, $urandom);
    drain();

    // count lowered under a running playback: next advance stops it
    set_regs(11'd1, 20'd0);
    send_at(lfsp_pkg::OP_TIME, $urandom);
    drain();

    // widest period the register holds
    set_regs(11'd3, 20'hFFFFF);
    send_at(lfsp_pkg::OP_PLAY, 32'd0);
    send_at(lfsp_pkg::OP_TIME, 32'd1048574);
    send_at(lfsp_pkg::OP_TIME, 32'd1048575);
    send_at(lfsp_pkg::OP_STOP, $urandom);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(11'd3, 20'd1);
        1: set_regs(11'd2, 20'($urandom_range(2, 5000)));
        2: set_regs(11'd1024, 20'($urandom_range(50, 2000)));
        3: set_regs(11'd0, 20'd500);
        4: set_regs(11'd4, 20'd1000000);
        default: set_regs(11'($urandom_range(1, 6)), 20'd0);
      endcase
      repeat (10) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          w = any_word(lfsp_pkg::OP_WRITE);
          if ($urandom_range(0, 2) != 0) w.fnum = 10'($urandom_range(0, 5));
        end else if (r < 38) begin
          w = any_word(lfsp_pkg::OP_PLAY);
        end else if (r < 47) begin
          w = any_word(lfsp_pkg::OP_STOP);
        end else begin
          w = any_word(lfsp_pkg::OP_TIME);
          w.now = pick_now();
        end
        w.hold = ($urandom_range(0, 29) == 0);
        send(w);
      end
      drain();
    end

    if (pix_expect.size() != 0) begin
      $display("%0t: %0d pixel words never arrived", $time, pix_expect.size());
      err_cnt++;
    end
    $display("covered %0d input words, %0d pixel words in %0d strip updates,",
             n_in, n_out, n_updates);
    $display("under %0d register settings with random idling on both streams", n_settings);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
